// ===== rtl/wsrm_pkg.sv =====
package wsrm_pkg;

	localparam int PATTERN_MAX_DEF = 32;
	localparam int PAT_BYTES       = 32;
	localparam int PAT_WORDS       = 4;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_IDX_W       = 3;
	localparam int LEN_REG_W       = 6;

	localparam logic [7:0] CHAR_STAR = 8'h2A;
	localparam logic [7:0] CHAR_DOT  = 8'h2E;

	localparam logic [CFG_IDX_W-1:0] REG_PAT_0_7   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_8_15  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_16_23 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_24_31 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd4;

	typedef logic [PAT_BYTES-1:0][7:0] pattern_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic [7:0] text_byte;
		logic       first;
		logic       advance;
	} step_t;

endpackage

// ===== rtl/wsrm_cfg_regs.sv =====
module wsrm_cfg_regs import wsrm_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output pattern_t              pattern,
	output logic [LEN_W-1:0]      eff_len
);

	logic [PAT_WORDS-1:0][CFG_DATA_W-1:0] pat_q;
	logic [LEN_REG_W-1:0]                 len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			len_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_PAT_0_7:   pat_q[0] <= wr_data;
				REG_PAT_8_15:  pat_q[1] <= wr_data;
				REG_PAT_16_23: pat_q[2] <= wr_data;
				REG_PAT_24_31: pat_q[3] <= wr_data;
				REG_PAT_LEN:   len_q    <= wr_data[LEN_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// byte 0 sits in bits 7:0 of the first word
	assign pattern = pat_q;

	// lengths beyond the cell count clamp to the cell count
	assign eff_len = (len_q > LEN_REG_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
		: len_q[LEN_W-1:0];

endmodule

// ===== rtl/wsrm_cell.sv =====
module wsrm_cell import wsrm_pkg::*; #(
	parameter int POS   = 1,
	parameter int LEN_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  step_t            step,
	input  logic [LEN_W-1:0] eff_len,
	input  logic [7:0]       pat_c,
	input  logic [7:0]       pat_prev,
	input  logic             old_prev,
	input  logic             nrow_prev2,
	input  logic             erow_prev2,
	output logic             old_bit,
	output logic             nrow_bit,
	output logic             erow_bit,
	output logic             hit
);

	localparam logic IS_EVEN  = 1'((POS % 2) == 0);
	localparam logic HAS_PREV = 1'(POS >= 2);

	logic row_q;
	logic active;
	logic same;
	logic b;

	assign active = (LEN_W'(POS) <= eff_len);

	// empty-text row: x* pairs may match nothing, as a prefix chain
	assign erow_bit = IS_EVEN & active & (pat_c == CHAR_STAR) & erow_prev2;

	assign old_bit = step.first ? erow_bit : row_q;

	assign same = (pat_prev == CHAR_DOT) || (pat_prev == step.text_byte);

	always_comb begin
		b = 1'b0;
		if (pat_c == CHAR_STAR) begin
			// leading star reads false
			b = HAS_PREV & (nrow_prev2 | (same & old_bit));
		end else if ((pat_c == CHAR_DOT) || (pat_c == step.text_byte)) begin
			b = old_prev;
		end
	end

	assign nrow_bit = b & active;
	assign hit      = nrow_bit & (LEN_W'(POS) == eff_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 1'b0;
		end else if (step.advance) begin
			row_q <= nrow_bit;
		end
	end

endmodule

// ===== rtl/wildcard_star_regex_matcher.sv =====
// Channel  | Handshake            | Payload
// in       | in_valid / in_stall  | text_byte, first_byte, last_byte
// out      | out_valid / out_stall| full_match, text_end
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One text byte per cycle while in_stall is low: the whole match row is updated by the cell chain in
// the cycle the request is taken, and the verdict is registered and appears in the cycle after.
// The star terms ripple through every second cell, which sets the clock limit.
// A request is taken while the output register is empty or being drained.
// Reset clears the row, the output valid flag and all configuration registers; full_match and text_end are not reset.
module wildcard_star_regex_matcher import wsrm_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            text_byte,
	input  logic                  first_byte,
	input  logic                  last_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  full_match,
	output logic                  text_end,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	pattern_t               pattern;
	logic [LEN_W-1:0]       eff_len;
	step_t                  step;
	logic [PATTERN_MAX:0]   old_row;
	logic [PATTERN_MAX:0]   nrow;
	logic [PATTERN_MAX:0]   erow;
	logic [PATTERN_MAX:1]   hits;
	logic                   accept;
	logic                   out_valid_q;
	logic                   full_match_q;
	logic                   text_end_q;

	assign cfg_ready = 1'b1;

	wsrm_cfg_regs #(
		.PATTERN_MAX(PATTERN_MAX),
		.LEN_W      (LEN_W)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid & cfg_ready),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.pattern (pattern),
		.eff_len (eff_len)
	);

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign step.text_byte = text_byte;
	assign step.first     = first_byte;
	assign step.advance   = accept;

	// position 0: empty prefix matches only the empty text
	assign old_row[0] = first_byte;
	assign nrow[0]    = 1'b0;
	assign erow[0]    = 1'b1;

	for (genvar j = 1; j <= PATTERN_MAX; j++) begin : g_cell
		logic [7:0] pat_prev;
		logic       nrow_prev2;
		logic       erow_prev2;

		if (j == 1) begin : g_head
			assign pat_prev   = '0;
			assign nrow_prev2 = 1'b0;
			assign erow_prev2 = 1'b0;
		end else begin : g_body
			assign pat_prev   = pattern[j-2];
			assign nrow_prev2 = nrow[j-2];
			assign erow_prev2 = erow[j-2];
		end

		wsrm_cell #(
			.POS  (j),
			.LEN_W(LEN_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (step),
			.eff_len   (eff_len),
			.pat_c     (pattern[j-1]),
			.pat_prev  (pat_prev),
			.old_prev  (old_row[j-1]),
			.nrow_prev2(nrow_prev2),
			.erow_prev2(erow_prev2),
			.old_bit   (old_row[j]),
			.nrow_bit  (nrow[j]),
			.erow_bit  (erow[j]),
			.hit       (hits[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			full_match_q <= |hits;
			text_end_q   <= last_byte;
		end
	end

	assign out_valid  = out_valid_q;
	assign full_match = full_match_q;
	assign text_end   = text_end_q;

endmodule

// ===== rtl/wsrm_checker.sv =====
module wsrm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic last_byte,
	input logic out_valid,
	input logic out_stall,
	input logic full_match,
	input logic text_end
);

	a_req_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted request produced no result");

	a_end_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (text_end == $past(last_byte)))
		else $error("text_end does not follow last_byte");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with output free");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(full_match) && $stable(text_end)))
		else $error("stalled result changed");

endmodule

bind wildcard_star_regex_matcher wsrm_checker u_wsrm_checker (.*);

// ===== bench/tb_wildcard_star_regex_matcher.sv =====
module tb_wildcard_star_regex_matcher import wsrm_pkg::*; ;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 450;
	localparam int HOLD_CYCLES = 60;
	localparam logic [7:0] LETTER_A = "a";

	typedef struct packed {
		logic full_match;
		logic text_end;
	} verdict_t;

	// mirrors the pattern registers and the match row; queues one verdict per request
	class match_scoreboard;
		logic [PAT_BYTES*8-1:0] pattern = '0;
		logic [LEN_REG_W-1:0] pat_len = '0;
		logic [PAT_BYTES:0] row = '0;
		verdict_t verdicts[$];
		int errors = 0;

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PAT_0_7:   pattern[63:0] = data;
				REG_PAT_8_15:  pattern[127:64] = data;
				REG_PAT_16_23: pattern[191:128] = data;
				REG_PAT_24_31: pattern[255:192] = data;
				REG_PAT_LEN:   pat_len = data[LEN_REG_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] pbyte(int k);
			return pattern[8*k +: 8];
		endfunction

		function void note_request(logic [7:0] b, logic first, logic last);
			int n;
			int j;
			logic open;
			logic same;
			logic [7:0] c;
			logic [PAT_BYTES:0] prior;
			logic [PAT_BYTES:0] nxt;
			verdict_t v;
			n = (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(pat_len);
			if (first) begin
				// empty text: leading x* pairs may match nothing
				prior = '0;
				prior[0] = 1'b1;
				open = 1'b1;
				for (j = 2; j <= n; j += 2) begin
					if (open && pbyte(j - 1) == CHAR_STAR && prior[j - 2])
						prior[j] = 1'b1;
					else
						open = 1'b0;
				end
			end else begin
				prior = row;
			end
			nxt = '0;
			for (j = 1; j <= n; j++) begin
				c = pbyte(j - 1);
				if (c == CHAR_STAR) begin
					// a star in the first position never matches
					if (j >= 2) begin
						same = (pbyte(j - 2) == CHAR_DOT) || (pbyte(j - 2) == b);
						nxt[j] = nxt[j - 2] | (same & prior[j]);
					end
				end else if (c == CHAR_DOT || c == b) begin
					nxt[j] = prior[j - 1];
				end
			end
			row = nxt;
			v.full_match = nxt[n];
			v.text_end = last;
			verdicts.push_back(v);
		endfunction

		function void check_result(logic fm, logic te);
			verdict_t v;
			if (verdicts.size() == 0) begin
				$display("%0t: unexpected result full_match %0b text_end %0b", $time, fm, te);
				errors++;
				return;
			end
			v = verdicts.pop_front();
			if (fm !== v.full_match) begin
				$display("%0t: full_match expected %0b, got %0b", $time, v.full_match, fm);
				errors++;
			end
			if (te !== v.text_end) begin
				$display("%0t: text_end expected %0b, got %0b", $time, v.text_end, te);
				errors++;
			end
		endfunction

		function int pending();
			return verdicts.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] text_byte = '0;
	logic first_byte = 1'b0;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic full_match;
	logic text_end;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	match_scoreboard sb = new();
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	bit hold_req = 1'b0;

	wildcard_star_regex_matcher u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_byte(text_byte),
		.first_byte(first_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.full_match(full_match),
		.text_end(text_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				sb.note_request(text_byte, first_byte, last_byte);
			if (out_valid && !out_stall)
				sb.check_result(full_match, text_end);
		end
	end

	// receiver: segments of differing stall density, plus a long hold on request
	initial begin : receiver
		int unsigned mode;
		int unsigned span;
		int unsigned k;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(4, 30);
				for (k = 0; k < span; k++) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= 1'($urandom_range(0, 1));
						2: out_stall <= (k % 3 == 0);
						default: out_stall <= ($urandom_range(0, 3) != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic f, input logic l);
		in_valid <= 1'b1;
		text_byte <= b;
		first_byte <= f;
		last_byte <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	// bursts of random length separated by random gaps
	task automatic pace();
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic load_pattern(input logic [PAT_BYTES*8-1:0] p, input logic [LEN_REG_W-1:0] n);
		write_reg(REG_PAT_0_7, p[63:0]);
		write_reg(REG_PAT_8_15, p[127:64]);
		write_reg(REG_PAT_16_23, p[191:128]);
		write_reg(REG_PAT_24_31, p[255:192]);
		write_reg(REG_PAT_LEN, CFG_DATA_W'(n));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [PAT_BYTES*8-1:0] str_pat(string s);
		logic [PAT_BYTES*8-1:0] p;
		int k;
		p = '0;
		for (k = 0; k < s.len() && k < PAT_BYTES; k++)
			p[8*k +: 8] = s[k];
		return p;
	endfunction

	task automatic send_str(input string s, input logic f, input logic l);
		int k;
		for (k = 0; k < s.len(); k++) begin
			send_item(s[k], f && k == 0, l && k == s.len() - 1);
			pace();
		end
	endtask

	function automatic logic [7:0] pick_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return LETTER_A + 8'($urandom_range(0, 2));
		else if (r < 80)
			return CHAR_STAR;
		else if (r < 85)
			return CHAR_DOT;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [PAT_BYTES*8-1:0] random_pattern();
		logic [PAT_BYTES*8-1:0] p;
		int unsigned r;
		int k;
		for (k = 0; k < PAT_BYTES; k++) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				p[8*k +: 8] = LETTER_A + 8'($urandom_range(0, 2));
			else if (r < 70)
				p[8*k +: 8] = CHAR_STAR;
			else if (r < 85)
				p[8*k +: 8] = CHAR_DOT;
			else
				p[8*k +: 8] = 8'($urandom_range(0, 255));
		end
		return p;
	endfunction

	function automatic logic [LEN_REG_W-1:0] random_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		else if (r < 63)
			return LEN_REG_W'($urandom_range(1, 8));
		else if (r < 83)
			return LEN_REG_W'($urandom_range(9, 32));
		else if (r < 93)
			return LEN_REG_W'($urandom_range(33, 63));
		return LEN_REG_W'(PAT_BYTES);
	endfunction

	task automatic send_text();
		int unsigned n;
		int unsigned k;
		n = $urandom_range(1, 10);
		for (k = 0; k < n; k++) begin
			send_item(pick_char(), k == 0, k == n - 1);
			pace();
		end
	endtask

	initial begin : stimulus
		int unsigned target;
		int unsigned phase_end;
		int unsigned phase;
		bit paused;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no first byte yet, empty pattern from reset
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
		wait_idle();
		load_pattern(str_pat("x*y*."), 5);
		send_str("z", 1'b1, 1'b1);
		send_str("xxyq", 1'b1, 1'b1);
		send_str("q", 1'b0, 1'b1);
		wait_idle();
		load_pattern(str_pat("*a"), 2);
		send_str("a", 1'b1, 1'b1);
		send_str("*a", 1'b1, 1'b1);
		wait_idle();
		// star repeating a star; text left open across the next reload
		load_pattern(str_pat("a**"), 3);
		send_str("a*", 1'b1, 1'b0);
		wait_idle();
		load_pattern(str_pat("a.*"), 3);
		send_str(".", 1'b0, 1'b1);
		send_str("*", 1'b1, 1'b1);
		wait_idle();
		// oversized length clamps to the full pattern
		load_pattern(str_pat(".*.*.*.*.*.*.*.*.*.*.*.*.*.*.*.*"), '1);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		wait_idle();
		load_pattern('1, LEN_REG_W'(PAT_BYTES));
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
		wait_idle();
		load_pattern('0, '0);
		send_item(LETTER_A, 1'b1, 1'b1);

		target = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < target) begin
			wait_idle();
			load_pattern(random_pattern(), random_len());
			phase_end = items_sent + $urandom_range(20, 60);
			paused = 1'b0;
			while (items_sent < phase_end) begin
				if (phase == 2 && !paused) begin
					// receiver holds off; keep offering until it lets go
					paused = 1'b1;
					hold_req = 1'b1;
					do begin
						send_item(pick_char(), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
					end while (hold_req);
				end else if (phase == 4 && !paused && items_sent > phase_end - 10) begin
					paused = 1'b1;
					wait_idle();
				end else if ($urandom_range(0, 6) == 0) begin
					send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
					pace();
				end else begin
					send_text();
				end
			end
			phase++;
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== wildcard_star_regex_matcher.f =====
rtl/wsrm_pkg.sv
rtl/wsrm_cfg_regs.sv
rtl/wsrm_cell.sv
rtl/wildcard_star_regex_matcher.sv
rtl/wsrm_checker.sv
bench/tb_wildcard_star_regex_matcher.sv
